>>> rtl/rps_pkg.sv
package rps_pkg;

    localparam int TABLES      = 2;
    localparam int MAX_RECTS   = 64;
    localparam int MAX_STEPS   = 256;
    localparam int QUEUE_DEPTH = 1024;

    localparam int COORD_W = 24;
    localparam int VP_W    = 23;
    localparam int GRID_W  = 1;
    localparam int OP_W    = 2;
    localparam int IDX_W   = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CNT_W   = $clog2(MAX_RECTS + 1);
    localparam int QAW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW     = $clog2(QUEUE_DEPTH + 1);
    localparam int BUD_W   = $clog2(MAX_STEPS + 1);
    localparam int DIV_N   = VP_W;
    localparam int DCNT_W  = $clog2(DIV_N + 1);

    localparam logic signed [COORD_W-1:0] MIN_BOTTOM = 24'sd1229;
    localparam logic [VP_W-1:0]           TOP_INSET  = 23'd2458;

    localparam int F_LEFT   = 0;
    localparam int F_RIGHT  = 1;
    localparam int F_TOP    = 2;
    localparam int F_BOTTOM = 3;

    localparam logic REG_VP_WIDTH  = 1'b0;
    localparam logic REG_VP_HEIGHT = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR   = 2'd0,
        OP_APPEND  = 2'd1,
        OP_RESOLVE = 2'd2
    } t_op;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] bottom;
        logic [COORD_W-1:0] right;
    } t_box;

    typedef struct packed {
        logic               valid;
        logic               hit;
        logic [1:0]         dir;
        t_box               box;
        logic [COORD_W-1:0] coord;
    } t_probe;

    typedef struct packed {
        logic              en;
        logic [GRID_W-1:0] tbl;
        logic [IDX_W-1:0]  idx;
        t_box              box;
    } t_wr;

    function automatic logic [25:0] f_sx26(input logic [COORD_W-1:0] a);
        return {{2{a[COORD_W-1]}}, a};
    endfunction

    function automatic logic [COORD_W-1:0] f_sat(input logic signed [25:0] v);
        logic [COORD_W-1:0] res;
        if (v > 26'sd8388607) begin
            res = 24'h7fffff;
        end else if (v < -26'sd8388608) begin
            res = 24'h800000;
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [3:0] f_flags(input t_box x, input logic [VP_W-1:0] hext,
                                           input logic signed [24:0] vext);
        logic [3:0] f;
        f = '0;
        if ($signed(x.left) <= 0) f[F_LEFT] = 1'b1;
        if ($signed({x.right[COORD_W-1], x.right}) > $signed({2'b00, hext}))
            f[F_RIGHT] = 1'b1;
        if ($signed(x.bottom) < MIN_BOTTOM) f[F_BOTTOM] = 1'b1;
        if ($signed({x.top[COORD_W-1], x.top}) > vext) f[F_TOP] = 1'b1;
        return f;
    endfunction

    function automatic logic [3:0] f_cat(input logic [3:0] f);
        logic [3:0] c;
        if (f[F_LEFT]) begin
            if (f[F_TOP]) c = 4'd8;
            else if (f[F_BOTTOM]) c = 4'd6;
            else c = 4'd4;
        end else if (f[F_TOP]) begin
            c = f[F_RIGHT] ? 4'd7 : 4'd2;
        end else if (f[F_RIGHT]) begin
            c = f[F_BOTTOM] ? 4'd5 : 4'd3;
        end else begin
            c = f[F_BOTTOM] ? 4'd1 : 4'd0;
        end
        return c;
    endfunction

    // direction order per category, first try in the low bits
    function automatic logic [7:0] f_order(input logic [3:0] cat);
        logic [7:0] o;
        case (cat)
            4'd0:    o = {DIR_LEFT,  DIR_DOWN,  DIR_RIGHT, DIR_UP};
            4'd1:    o = {DIR_UP,    DIR_RIGHT, DIR_UP,    DIR_LEFT};
            4'd2:    o = {DIR_DOWN,  DIR_RIGHT, DIR_DOWN,  DIR_LEFT};
            4'd3:    o = {DIR_LEFT,  DIR_DOWN,  DIR_LEFT,  DIR_UP};
            4'd4:    o = {DIR_RIGHT, DIR_DOWN,  DIR_RIGHT, DIR_UP};
            4'd5:    o = {DIR_LEFT,  DIR_UP,    DIR_LEFT,  DIR_UP};
            4'd6:    o = {DIR_RIGHT, DIR_UP,    DIR_RIGHT, DIR_UP};
            4'd7:    o = {DIR_LEFT,  DIR_DOWN,  DIR_LEFT,  DIR_DOWN};
            4'd8:    o = {DIR_RIGHT, DIR_DOWN,  DIR_RIGHT, DIR_DOWN};
            default: o = '0;
        endcase
        return o;
    endfunction

    // apply the shift recorded by the cell chain
    function automatic t_box f_shift(input t_probe p);
        t_box o;
        o = p.box;
        if (p.hit) begin
            case (p.dir)
                DIR_UP: begin
                    o.top    = f_sat($signed(f_sx26(p.box.top) + f_sx26(p.coord)
                                             - f_sx26(p.box.bottom)));
                    o.bottom = p.coord;
                end
                DIR_LEFT: begin
                    o.left  = f_sat($signed(f_sx26(p.box.left) - f_sx26(p.box.right)
                                            + f_sx26(p.coord)));
                    o.right = p.coord;
                end
                DIR_RIGHT: begin
                    o.left  = p.coord;
                    o.right = f_sat($signed(f_sx26(p.box.right) + f_sx26(p.coord)
                                            - f_sx26(p.box.left)));
                end
                default: begin
                    o.top    = p.coord;
                    o.bottom = f_sat($signed(f_sx26(p.box.bottom) - f_sx26(p.box.top)
                                             + f_sx26(p.coord)));
                end
            endcase
        end
        return o;
    endfunction

endpackage

>>> rtl/rps_cell.sv
module rps_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [rps_pkg::IDX_W-1:0]  i_idx,
    input  rps_pkg::t_wr               i_wr,
    input  logic [rps_pkg::GRID_W-1:0] i_sel,
    input  logic [rps_pkg::CNT_W-1:0]  i_lim,
    input  rps_pkg::t_probe            i_probe,
    output rps_pkg::t_probe            o_probe
);
    import rps_pkg::*;

    t_box   r_obs [TABLES];
    t_probe r_probe;
    t_probe n_probe;
    t_box   k;
    logic   overlap;

    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.idx == i_idx) begin
            r_obs[i_wr.tbl] <= i_wr.box;
        end
    end

    always_comb begin
        k = r_obs[i_sel];
        overlap = ($signed(k.left) < $signed(i_probe.box.right)) &&
                  ($signed(k.right) > $signed(i_probe.box.left)) &&
                  ($signed(k.bottom) < $signed(i_probe.box.top)) &&
                  ($signed(k.top) > $signed(i_probe.box.bottom));
        n_probe = i_probe;
        if (i_probe.valid && !i_probe.hit && ({1'b0, i_idx} < {1'b0, i_lim}) && overlap) begin
            n_probe.hit = 1'b1;
            unique case (i_probe.dir)
                DIR_UP:    n_probe.coord = k.top;
                DIR_LEFT:  n_probe.coord = k.left;
                DIR_RIGHT: n_probe.coord = k.right;
                DIR_DOWN:  n_probe.coord = k.bottom;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else begin
            r_probe.valid <= n_probe.valid;
        end
        r_probe.hit   <= n_probe.hit;
        r_probe.dir   <= n_probe.dir;
        r_probe.box   <= n_probe.box;
        r_probe.coord <= n_probe.coord;
    end

    assign o_probe = r_probe;

endmodule

>>> rtl/rps_div.sv
module rps_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [rps_pkg::VP_W-1:0] i_dividend,
    input  logic [23:0]              i_divisor,
    output logic                     o_done,
    output logic [rps_pkg::VP_W-1:0] o_quot
);
    import rps_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [23:0]       r_rem;
    logic [VP_W-1:0]   r_q;
    logic [23:0]       r_d;
    logic [24:0]       trial;
    logic [24:0]       diff;

    always_comb begin
        trial = {r_rem, r_q[VP_W-1]};
        diff  = trial - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DIV_N);
                r_rem  <= '0;
                r_q    <= i_dividend;
                r_d    <= i_divisor;
            end else if (r_busy) begin
                if (!diff[24]) begin
                    r_rem <= diff[23:0];
                    r_q   <= {r_q[VP_W-2:0], 1'b1};
                end else begin
                    r_rem <= trial[23:0];
                    r_q   <= {r_q[VP_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

>>> rtl/rect_placement_search.sv
// Rectangle placement search. Clear and append items keep the input ready. A
// resolve item runs two divisions for the step budget (skipped when the input
// has zero height or width), then up to MAX_STEPS search steps. The obstacle
// rectangles sit in a chain of MAX_RECTS cells, and the four shifted candidates
// of a step travel through it one behind the other. Ready is high only while no
// resolve is running; the finished rectangle waits in the output register, so
// new items are taken while it is not yet collected.
module rect_placement_search
    import rps_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [VP_W-1:0]     i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [OP_W-1:0]     i_op,
    input  logic [GRID_W-1:0]   i_grid,
    input  logic [COORD_W-1:0]  i_in_top,
    input  logic [COORD_W-1:0]  i_in_left,
    input  logic [COORD_W-1:0]  i_in_bottom,
    input  logic [COORD_W-1:0]  i_in_right,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [COORD_W-1:0]  o_out_top,
    output logic [COORD_W-1:0]  o_out_left,
    output logic [COORD_W-1:0]  o_out_bottom,
    output logic [COORD_W-1:0]  o_out_right,
    output logic                o_placed
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_PREP  = 11'b00000000010,
        S_DIV1  = 11'b00000000100,
        S_DIV2  = 11'b00000001000,
        S_MUL   = 11'b00000010000,
        S_CLAMP = 11'b00000100000,
        S_POP   = 11'b00001000000,
        S_RD    = 11'b00010000000,
        S_INJ   = 11'b00100000000,
        S_WAIT  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state              r_state;
    logic [VP_W-1:0]     r_vw;
    logic [VP_W-1:0]     r_vh;
    logic [CNT_W-1:0]    r_cnt [TABLES];
    t_box                r_in;
    logic [GRID_W-1:0]   r_grid;
    logic [3:0]          r_cat;
    logic signed [24:0]  r_qa;
    logic signed [24:0]  r_qb;
    logic signed [49:0]  r_prod;
    logic [BUD_W-1:0]    r_budget;
    logic [BUD_W-1:0]    r_step;
    logic [QAW-1:0]      r_head;
    logic [QCW-1:0]      r_qcnt;
    t_box                r_cur;
    logic [1:0]          r_s;
    logic [1:0]          r_got;
    logic                r_found;
    t_box                r_res;
    logic                r_res_placed;
    logic                r_ov;
    t_box                r_out;
    logic                r_out_placed;
    t_box                r_mem [QUEUE_DEPTH];
    t_box                r_rdata;

    logic                in_acc;
    logic                grid_ok;
    t_box                in_box;
    t_wr                 wr;
    logic [CNT_W-1:0]    lim;
    logic signed [24:0]  vext;
    logic signed [24:0]  h;
    logic signed [24:0]  w;
    logic [3:0]          f0;
    t_box                clamped;
    logic                dims_zero;
    logic                div_start;
    logic [VP_W-1:0]     div_dvd;
    logic [23:0]         div_dsr;
    logic                div_done;
    logic [VP_W-1:0]     div_q;
    logic signed [24:0]  q_inc;
    t_probe              chain [MAX_RECTS+1];
    t_probe              p_out;
    t_box                shifted;
    logic                collect;
    logic                same;
    logic                push;
    logic [QCW:0]        push_sum;
    logic [QAW-1:0]      push_addr;
    logic                mem_we;
    logic [QAW-1:0]      mem_wa;
    t_box                mem_wd;
    logic                mem_re;
    logic [7:0]          order;

    assign in_acc  = i_in_valid && o_in_ready;
    assign grid_ok = (32'(i_grid) < TABLES);
    assign in_box  = '{top: i_in_top, left: i_in_left, bottom: i_in_bottom, right: i_in_right};

    always_comb begin
        wr.en  = in_acc && (i_op == OP_APPEND) && grid_ok &&
                 (r_cnt[i_grid] < CNT_W'(MAX_RECTS));
        wr.tbl = i_grid;
        wr.idx = r_cnt[i_grid][IDX_W-1:0];
        wr.box = in_box;
        lim    = (32'(r_grid) < TABLES) ? r_cnt[r_grid] : '0;
    end

    always_comb begin
        vext = $signed({2'b00, r_vh}) - $signed({2'b00, TOP_INSET});
        h    = $signed({r_in.top[COORD_W-1], r_in.top}) -
               $signed({r_in.bottom[COORD_W-1], r_in.bottom});
        w    = $signed({r_in.right[COORD_W-1], r_in.right}) -
               $signed({r_in.left[COORD_W-1], r_in.left});
        f0   = f_flags(r_in, r_vw, vext);
        clamped = r_in;
        if (f0[F_TOP]) begin
            clamped.top    = vext[COORD_W-1:0];
            clamped.bottom = f_sat($signed({vext[24], vext}) - $signed({h[24], h}));
        end else if (f0[F_BOTTOM]) begin
            clamped.bottom = MIN_BOTTOM;
            clamped.top    = f_sat($signed({{2{MIN_BOTTOM[COORD_W-1]}}, MIN_BOTTOM})
                                   + $signed({h[24], h}));
        end
        if (f0[F_LEFT]) begin
            clamped.left  = '0;
            clamped.right = f_sat($signed({w[24], w}));
        end else if (f0[F_RIGHT]) begin
            clamped.right = {1'b0, r_vw};
            clamped.left  = f_sat($signed({3'b000, r_vw}) - $signed({w[24], w}));
        end
        dims_zero = (h == 25'sd0) || (w == 25'sd0);
    end

    always_comb begin
        div_start = ((r_state == S_PREP) && !dims_zero) || ((r_state == S_DIV1) && div_done);
        if (r_state == S_PREP) begin
            div_dvd = r_vh;
            div_dsr = h[24] ? 24'(-h) : h[23:0];
        end else begin
            div_dvd = r_vw;
            div_dsr = w[24] ? 24'(-w) : w[23:0];
        end
        if (r_state == S_DIV1) begin
            q_inc = (h[24] ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q})) + 25'sd1;
        end else begin
            q_inc = (w[24] ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q})) + 25'sd1;
        end
    end

    rps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    always_comb begin
        order = f_order(r_cat);
        chain[0].valid = (r_state == S_INJ);
        chain[0].hit   = 1'b0;
        chain[0].dir   = order[{r_s, 1'b0} +: 2];
        chain[0].box   = r_cur;
        chain[0].coord = '0;
    end

    for (genvar gi = 0; gi < MAX_RECTS; gi++) begin : g_cell
        rps_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(gi)),
            .i_wr    (wr),
            .i_sel   (r_grid),
            .i_lim   (lim),
            .i_probe (chain[gi]),
            .o_probe (chain[gi+1])
        );
    end

    always_comb begin
        p_out     = chain[MAX_RECTS];
        shifted   = f_shift(p_out);
        collect   = p_out.valid && ((r_state == S_INJ) || (r_state == S_WAIT));
        same      = (shifted == p_out.box);
        push      = collect && !r_found && !same && (r_qcnt < QCW'(QUEUE_DEPTH));
        push_sum  = (QCW+1)'(r_head) + (QCW+1)'(r_qcnt);
        push_addr = (push_sum >= (QCW+1)'(QUEUE_DEPTH)) ?
                    QAW'(push_sum - (QCW+1)'(QUEUE_DEPTH)) : QAW'(push_sum);
        mem_we    = (r_state == S_PREP) || push;
        mem_wa    = (r_state == S_PREP) ? '0 : push_addr;
        mem_wd    = (r_state == S_PREP) ? clamped : shifted;
        mem_re    = (r_state == S_POP);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vw <= 23'd87381;
            r_vh <= 23'd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_VP_WIDTH:  r_vw <= i_cfg_data;
                REG_VP_HEIGHT: r_vh <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TABLES; t++) begin
                r_cnt[t] <= '0;
            end
        end else if (in_acc && grid_ok) begin
            if (i_op == OP_CLEAR) begin
                r_cnt[i_grid] <= '0;
            end else if (wr.en) begin
                r_cnt[i_grid] <= r_cnt[i_grid] + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_found <= 1'b0;
        end else begin
            if (r_ov && i_out_ready && r_state != S_OUT) begin
                r_ov <= 1'b0;
            end
            if (collect) begin
                r_got <= r_got + 1'b1;
                if (!r_found && same) begin
                    r_found      <= 1'b1;
                    r_res        <= shifted;
                    r_res_placed <= 1'b1;
                end
                if (push) begin
                    r_qcnt <= r_qcnt + 1'b1;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_op == OP_RESOLVE) begin
                        r_in    <= in_box;
                        r_grid  <= i_grid;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_cat  <= f_cat(f0);
                    r_head <= '0;
                    r_qcnt <= QCW'(1);
                    r_step <= '0;
                    if (dims_zero) begin
                        r_budget <= BUD_W'(1);
                        r_state  <= S_POP;
                    end else begin
                        r_state <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (div_done) begin
                        r_qa    <= q_inc;
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (div_done) begin
                        r_qb    <= q_inc;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= r_qa * r_qb;
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    if (r_prod < 50'sd0) begin
                        r_budget <= '0;
                    end else if (r_prod > 50'(MAX_STEPS)) begin
                        r_budget <= BUD_W'(MAX_STEPS);
                    end else begin
                        r_budget <= r_prod[BUD_W-1:0];
                    end
                    r_state <= S_POP;
                end
                S_POP: begin
                    if (r_step >= r_budget || r_qcnt == '0) begin
                        r_res        <= r_in;
                        r_res_placed <= 1'b0;
                        r_state      <= S_OUT;
                    end else begin
                        r_head  <= (r_head == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                        r_qcnt  <= r_qcnt - 1'b1;
                        r_step  <= r_step + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    if (f_flags(r_rdata, r_vw, vext) != 4'd0) begin
                        r_state <= S_POP;
                    end else begin
                        r_cur   <= r_rdata;
                        r_s     <= '0;
                        r_got   <= '0;
                        r_found <= 1'b0;
                        r_state <= S_INJ;
                    end
                end
                S_INJ: begin
                    r_s <= r_s + 1'b1;
                    if (r_s == 2'd3) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (collect && r_got == 2'd3) begin
                        r_state <= (r_found || same) ? S_OUT : S_POP;
                    end
                end
                S_OUT: begin
                    if (!r_ov || i_out_ready) begin
                        r_out        <= r_res;
                        r_out_placed <= r_res_placed;
                        r_ov         <= 1'b1;
                        r_found      <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_ov;
    assign o_out_top    = r_out.top;
    assign o_out_left   = r_out.left;
    assign o_out_bottom = r_out.bottom;
    assign o_out_right  = r_out.right;
    assign o_placed     = r_out_placed;

endmodule

>>> rtl/rps_checker.sv
module rps_checker
    import rps_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_we,
    input logic               i_cfg_idx,
    input logic [VP_W-1:0]    i_cfg_data,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic [OP_W-1:0]    i_op,
    input logic [GRID_W-1:0]  i_grid,
    input logic [COORD_W-1:0] i_in_top,
    input logic [COORD_W-1:0] i_in_left,
    input logic [COORD_W-1:0] i_in_bottom,
    input logic [COORD_W-1:0] i_in_right,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [COORD_W-1:0] o_out_top,
    input logic [COORD_W-1:0] o_out_left,
    input logic [COORD_W-1:0] o_out_bottom,
    input logic [COORD_W-1:0] o_out_right,
    input logic               o_placed
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_top) &&
        $stable(o_out_left) && $stable(o_out_bottom) && $stable(o_out_right) &&
        $stable(o_placed))
        else $error("output item changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("not idle after reset");

    a_resolve_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_op == OP_RESOLVE |=> !o_in_ready)
        else $error("resolve item did not start a search");

    a_table_op_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_op != OP_RESOLVE |=> o_in_ready)
        else $error("table item blocked the input");

    a_result_at_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result shown while search still running");

endmodule

bind rect_placement_search rps_checker u_rps_checker (.*);

>>> dv/tb_top.sv
module tb_top;
    import rps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 100_000_000;

    typedef struct {
        int t, l, b, r;
    } rbox_t;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [GRID_W-1:0]  grid;
        logic [COORD_W-1:0] t, l, b, r;
    } item_t;

    typedef struct {
        rbox_t box;
        logic  placed;
    } placement_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [VP_W-1:0]    i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [OP_W-1:0]    i_op;
    logic [GRID_W-1:0]  i_grid;
    logic [COORD_W-1:0] i_in_top, i_in_left, i_in_bottom, i_in_right;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [COORD_W-1:0] o_out_top, o_out_left, o_out_bottom, o_out_right;
    logic               o_placed;

    rect_placement_search DUT (.*);

    // shadow state
    int unsigned vp_w = 87381;
    int unsigned vp_h = 65536;
    rbox_t       obst [TABLES][MAX_RECTS];
    int          obst_n [TABLES];
    rbox_t       ring [QUEUE_DEPTH];
    int          order [9][4] = '{'{0, 2, 3, 1}, '{1, 0, 2, 0}, '{1, 3, 2, 3},
                                  '{0, 1, 3, 1}, '{0, 2, 3, 2}, '{0, 1, 0, 1},
                                  '{0, 2, 0, 2}, '{3, 1, 3, 1}, '{3, 2, 3, 2}};

    item_t      pending [$];
    placement_t placements [$];
    item_t      cur;
    int         errors = 0;
    longint     cycles = 0;
    bit         took = 0;
    bit         calm = 0;
    int         in_gap = 0;
    int         out_gap = 0;
    int         hold_off = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int sat24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return int'(v);
    endfunction

    function automatic logic [3:0] edge_flags(rbox_t x, longint hext, longint vext);
        logic [3:0] f;
        f = '0;
        f[F_LEFT]   = (x.l <= 0);
        f[F_RIGHT]  = (longint'(x.r) > hext);
        f[F_BOTTOM] = (x.b < 1229);
        f[F_TOP]    = (longint'(x.t) > vext);
        return f;
    endfunction

    function automatic int category(logic [3:0] f);
        if (f[F_LEFT]) return f[F_TOP] ? 8 : (f[F_BOTTOM] ? 6 : 4);
        if (f[F_TOP]) return f[F_RIGHT] ? 7 : 2;
        if (f[F_RIGHT]) return f[F_BOTTOM] ? 5 : 3;
        return f[F_BOTTOM] ? 1 : 0;
    endfunction

    function automatic rbox_t push_off(int g, rbox_t x, int dir);
        rbox_t o;
        rbox_t k;
        longint a;
        o = x;
        for (int i = 0; i < obst_n[g]; i++) begin
            k = obst[g][i];
            if (k.l < x.r && k.r > x.l && k.b < x.t && k.t > x.b) begin
                case (dir)
                    0: begin
                        a = longint'(k.t) - x.b;
                        o.t = sat24(x.t + a);
                        o.b = sat24(x.b + a);
                    end
                    1: begin
                        a = longint'(x.r) - k.l;
                        o.l = sat24(x.l - a);
                        o.r = sat24(x.r - a);
                    end
                    2: begin
                        a = longint'(k.r) - x.l;
                        o.l = sat24(x.l + a);
                        o.r = sat24(x.r + a);
                    end
                    default: begin
                        a = longint'(x.t) - k.b;
                        o.t = sat24(x.t - a);
                        o.b = sat24(x.b - a);
                    end
                endcase
                return o;
            end
        end
        return o;
    endfunction

    function automatic placement_t find_spot(int g, rbox_t in);
        longint hext, vh, vext, h, w, budget;
        logic [3:0] f;
        int cat, head, cnt;
        rbox_t c, now, adj;
        placement_t res;
        hext = vp_w;
        vh = vp_h;
        vext = vh - 2458;
        h = longint'(in.t) - in.b;
        w = longint'(in.r) - in.l;
        f = edge_flags(in, hext, vext);
        cat = category(f);
        c = in;
        if (f[F_TOP]) begin
            c.t = sat24(vext);
            c.b = sat24(vext - h);
        end else if (f[F_BOTTOM]) begin
            c.b = 1229;
            c.t = sat24(1229 + h);
        end
        if (f[F_LEFT]) begin
            c.l = 0;
            c.r = sat24(w);
        end else if (f[F_RIGHT]) begin
            c.r = sat24(hext);
            c.l = sat24(hext - w);
        end
        if (h == 0 || w == 0) budget = 1;
        else budget = (vh / h + 1) * (hext / w + 1);
        if (budget > MAX_STEPS) budget = MAX_STEPS;
        ring[0] = c;
        head = 0;
        cnt = 1;
        for (longint s = 0; s < budget && cnt > 0; s++) begin
            now = ring[head];
            head = (head + 1) % QUEUE_DEPTH;
            cnt--;
            if (edge_flags(now, hext, vext) != 0) continue;
            for (int d = 0; d < 4; d++) begin
                adj = push_off(g, now, order[cat][d]);
                if (adj == now) begin
                    res.box = adj;
                    res.placed = 1'b1;
                    return res;
                end
                if (cnt < QUEUE_DEPTH) begin
                    ring[(head + cnt) % QUEUE_DEPTH] = adj;
                    cnt++;
                end
            end
        end
        res.box = in;
        res.placed = 1'b0;
        return res;
    endfunction

    task automatic apply_item(item_t it);
        rbox_t x;
        x.t = $signed(it.t);
        x.l = $signed(it.l);
        x.b = $signed(it.b);
        x.r = $signed(it.r);
        case (it.op)
            OP_CLEAR: obst_n[it.grid] = 0;
            OP_APPEND: begin
                if (obst_n[it.grid] < MAX_RECTS) begin
                    obst[it.grid][obst_n[it.grid]] = x;
                    obst_n[it.grid]++;
                end
            end
            OP_RESOLVE: placements = {placements, find_spot(it.grid, x)};
            default: ;
        endcase
    endtask

    task automatic queue_item(item_t it);
        pending = {pending, it};
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || took) begin
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pending.size() > 0) begin
                cur = pending[0];
                pending.delete(0);
                i_op <= cur.op;
                i_grid <= cur.grid;
                i_in_top <= cur.t;
                i_in_left <= cur.l;
                i_in_bottom <= cur.b;
                i_in_right <= cur.r;
                i_in_valid <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 15);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        took = 0;
    end

    // receiver
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off--;
            i_out_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0) out_gap = $urandom_range(1, 15);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        placement_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                took = 1;
                apply_item(cur);
            end
            if (o_out_valid && i_out_ready) begin
                if (placements.size() == 0) begin
                    $display("%0t unexpected result %h %h %h %h %b", $realtime, o_out_top,
                             o_out_left, o_out_bottom, o_out_right, o_placed);
                    errors++;
                end else begin
                    e = placements[0];
                    placements.delete(0);
                    if (o_out_top !== e.box.t[23:0]) begin
                        $display("%0t top exp %h got %h", $realtime, e.box.t[23:0], o_out_top);
                        errors++;
                    end
                    if (o_out_left !== e.box.l[23:0]) begin
                        $display("%0t left exp %h got %h", $realtime, e.box.l[23:0],
                                 o_out_left);
                        errors++;
                    end
                    if (o_out_bottom !== e.box.b[23:0]) begin
                        $display("%0t bottom exp %h got %h", $realtime, e.box.b[23:0],
                                 o_out_bottom);
                        errors++;
                    end
                    if (o_out_right !== e.box.r[23:0]) begin
                        $display("%0t right exp %h got %h", $realtime, e.box.r[23:0],
                                 o_out_right);
                        errors++;
                    end
                    if (o_placed !== e.placed) begin
                        $display("%0t placed exp %b got %b", $realtime, e.placed, o_placed);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic item_t mk(logic [1:0] op, logic g, longint t, longint l,
                                 longint b, longint r);
        item_t it;
        it.op = op;
        it.grid = g;
        it.t = COORD_W'(sat24(t));
        it.l = COORD_W'(sat24(l));
        it.b = COORD_W'(sat24(b));
        it.r = COORD_W'(sat24(r));
        return it;
    endfunction

    function automatic longint span(longint n);
        return (n <= 0) ? 0 : longint'($urandom_range(0, int'(n)));
    endfunction

    // resolve sized to keep the search budget modest
    function automatic item_t mk_resolve(logic g);
        longint vh, hw, h, w, b, l;
        vh = vp_h;
        hw = vp_w;
        if ($urandom_range(0, 99) == 0) begin
            h = span(vh / 8);
            w = span(hw / 8);
        end else begin
            h = vh / 4 + span(vh) + 1;
            w = hw / 4 + span(hw) + 1;
        end
        if ($urandom_range(0, 15) == 0) h = -h;
        if ($urandom_range(0, 15) == 0) w = 0;
        b = span(vh + vh / 2) - vh / 4;
        l = span(hw + hw / 2) - hw / 4;
        return mk(OP_RESOLVE, g, b + h, l, b, l + w);
    endfunction

    function automatic item_t mk_obstacle(logic g);
        longint b, l;
        b = span(vp_h) - vp_h / 8;
        l = span(vp_w) - vp_w / 8;
        return mk(OP_APPEND, g, b + span(vp_h / 2), l, b, l + span(vp_w / 2));
    endfunction

    function automatic item_t mk_any();
        item_t it;
        it.op = OP_W'($urandom_range(0, 3));
        it.grid = GRID_W'($urandom_range(0, 1));
        it.t = COORD_W'($urandom);
        it.l = COORD_W'($urandom);
        it.b = COORD_W'($urandom);
        it.r = COORD_W'($urandom);
        if (it.op == OP_RESOLVE) begin
            it.b = {1'b1, it.b[22:0]};
            it.t = {1'b0, it.t[22:0]};
        end
        return it;
    endfunction

    task automatic write_reg(logic idx, logic [VP_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx == REG_VP_WIDTH) vp_w = val;
        else vp_h = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending.size() > 0 || i_in_valid || placements.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        int pick;
        logic g;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            g = 1'($urandom_range(0, 1));
            if (pick < 3) queue_item(mk(OP_CLEAR, g, 0, 0, 0, 0));
            else if (pick < 45) queue_item(mk_obstacle(g));
            else if (pick < 92) queue_item(mk_resolve(g));
            else queue_item(mk_any());
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_VP_WIDTH;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        i_op = OP_CLEAR;
        i_grid = '0;
        i_in_top = '0;
        i_in_left = '0;
        i_in_bottom = '0;
        i_in_right = '0;
        obst_n = '{default: 0};
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_reg(REG_VP_WIDTH, 23'd87381);
        write_reg(REG_VP_HEIGHT, 23'd65536);

        // directed: every category, zero and negative size, extremes, unused op
        queue_item(mk(2'd3, 0, 1, 1, 1, 1));
        queue_item(mk(OP_RESOLVE, 0, 30000, 20000, 10000, 50000));
        queue_item(mk(OP_APPEND, 0, 40000, 10000, 5000, 60000));
        queue_item(mk(OP_APPEND, 1, 8388607, -8388608, -8388608, 8388607));
        queue_item(mk(OP_RESOLVE, 0, 30000, 20000, 10000, 50000));
        queue_item(mk(OP_RESOLVE, 0, 20000, 20000, 0, 50000));
        queue_item(mk(OP_RESOLVE, 0, 70000, 20000, 30000, 50000));
        queue_item(mk(OP_RESOLVE, 0, 30000, 50000, 10000, 90000));
        queue_item(mk(OP_RESOLVE, 0, 70000, 50000, 30000, 90000));
        queue_item(mk(OP_RESOLVE, 0, 20000, 50000, 0, 90000));
        queue_item(mk(OP_RESOLVE, 0, 30000, 0, 10000, 40000));
        queue_item(mk(OP_RESOLVE, 0, 20000, -5000, 0, 40000));
        queue_item(mk(OP_RESOLVE, 0, 70000, -5000, 30000, 40000));
        queue_item(mk(OP_RESOLVE, 0, 30000, 20000, 30000, 50000));
        queue_item(mk(OP_RESOLVE, 0, 30000, 20000, 10000, 20000));
        queue_item(mk(OP_RESOLVE, 0, 10000, 20000, 30000, 50000));
        queue_item(mk(OP_RESOLVE, 1, 8388607, -8388608, -8388608, 8388607));
        queue_item(mk(OP_RESOLVE, 1, -8388608, 8388607, 8388607, -8388608));
        queue_item(mk(OP_CLEAR, 1, 0, 0, 0, 0));
        queue_item(mk(OP_RESOLVE, 1, 30000, 20000, 10000, 50000));
        drain();

        // receiver holds off while items keep coming
        hold_off = 3000;
        random_phase(200);
        drain();

        write_reg(REG_VP_WIDTH, 23'd8388607);
        write_reg(REG_VP_HEIGHT, 23'd8388607);
        random_phase(180);
        drain();

        write_reg(REG_VP_WIDTH, 23'd0);
        write_reg(REG_VP_HEIGHT, 23'd0);
        random_phase(120);
        drain();

        write_reg(REG_VP_WIDTH, VP_W'($urandom_range(1000, 4000000)));
        write_reg(REG_VP_HEIGHT, VP_W'($urandom_range(1000, 4000000)));
        random_phase(200);
        drain();

        write_reg(REG_VP_WIDTH, 23'd87381);
        write_reg(REG_VP_HEIGHT, 23'd65536);
        random_phase(150);
        drain();
        calm = 1;
        random_phase(150);
        drain();

        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
